// ===== rtl/core/prl_pkg.sv =====
// shared types, codes and helpers for the positional record list
`default_nettype none
package prl_pkg;

    localparam int CAPACITY_DEFAULT   = 32;
    localparam int NAME_BYTES_DEFAULT = 32;

    // command codes
    localparam logic [2:0] OP_APPEND   = 3'd0;
    localparam logic [2:0] OP_INSERT   = 3'd1;
    localparam logic [2:0] OP_DELETE   = 3'd2;
    localparam logic [2:0] OP_DUMP_REV = 3'd3;
    localparam logic [2:0] OP_DUMP_FWD = 3'd4;

    // result status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_INDEX   = 3'd1;
    localparam logic [2:0] ST_EMPTY       = 3'd2;
    localparam logic [2:0] ST_NOT_REACHED = 3'd3;
    localparam logic [2:0] ST_FULL        = 3'd4;
    localparam logic [2:0] ST_RECORD      = 3'd5;

    typedef struct packed {
        logic [31:0] id;
        logic [63:0] w0;
        logic [63:0] w1;
        logic [63:0] w2;
        logic [63:0] w3;
        logic [31:0] score;
    } t_rec;

    // bytes of name word w that lie below nbytes are kept
    function automatic logic [63:0] name_mask(input int unsigned w, input int unsigned nbytes);
        int unsigned lo;
        logic [63:0] m;
        lo = 8 * w;
        if (lo + 8 <= nbytes) begin
            m = '1;
        end else if (lo >= nbytes) begin
            m = '0;
        end else begin
            m = (64'd1 << (8 * (nbytes - lo))) - 64'd1;
        end
        return m;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/positional_record_list.sv =====
// Positional record list: ordered record store in one memory with shifting insert and delete.
//
// Input channel (i_valid / o_ready) carries one command request: append, insert at i_pos,
// delete at i_pos, dump reverse or dump forward. o_ready is high only while the block is
// idle; one command is worked on at a time. Result channel (o_valid / i_ready) returns one
// status result per edit command, or one result per stored record on a dump (ST_EMPTY if the
// list is empty), o_last marking the final one. Unused op codes are dropped with no result.
// Records live in a single memory with one write and one registered read port, one record
// per row. Insert and delete move the rows behind the index one row per cycle (read the
// source, write the destination while reading the next source).
// An edit that moves m rows (m is at most the list length) runs S_MOVE_RD, then S_MOVE_WR
// for each row, then S_RESP; an error or no-move edit goes straight to S_RESP. A dump reads
// its first row in S_DUMP_RD, then gives one result per cycle from S_DUMP_LD unless stalled.
// A stalled receiver holds the output register; dumps pause, edits wait before commit.
// Reset empties the list (count to zero) and drops any result in flight; the memory
// itself is not cleared, only rows below the count are ever read.
`default_nettype none
module positional_record_list #(
    parameter int CAPACITY   = prl_pkg::CAPACITY_DEFAULT,
    parameter int NAME_BYTES = prl_pkg::NAME_BYTES_DEFAULT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [2:0]  i_op,
    input  wire logic signed [6:0] i_pos,
    input  wire logic signed [31:0] i_rec_id,
    input  wire logic [63:0] i_name_w0,
    input  wire logic [63:0] i_name_w1,
    input  wire logic [63:0] i_name_w2,
    input  wire logic [63:0] i_name_w3,
    input  wire logic [31:0] i_score_bits,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_status,
    output logic signed [31:0] o_out_id,
    output logic [63:0]      o_out_w0,
    output logic [63:0]      o_out_w1,
    output logic [63:0]      o_out_w2,
    output logic [63:0]      o_out_w3,
    output logic [31:0]      o_out_score,
    output logic             o_last
);

    localparam int AW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [63:0] MASK0 = prl_pkg::name_mask(0, NAME_BYTES);
    localparam logic [63:0] MASK1 = prl_pkg::name_mask(1, NAME_BYTES);
    localparam logic [63:0] MASK2 = prl_pkg::name_mask(2, NAME_BYTES);
    localparam logic [63:0] MASK3 = prl_pkg::name_mask(3, NAME_BYTES);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_MOVE_RD = 6'b000010,
        S_MOVE_WR = 6'b000100,
        S_RESP    = 6'b001000,
        S_DUMP_RD = 6'b010000,
        S_DUMP_LD = 6'b100000
    } t_state;

    prl_pkg::t_rec r_mem [CAPACITY];
    prl_pkg::t_rec r_rdata;
    prl_pkg::t_rec r_new;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_src, n_src;
    logic [AW-1:0] r_dst, n_dst;
    logic [AW-1:0] r_k, n_k;
    logic [CW-1:0] r_left, n_left;
    logic          r_down, n_down;
    logic          r_cmt_ins, n_cmt_ins;
    logic          r_cmt_del, n_cmt_del;
    logic [2:0]    r_st, n_st;

    logic          r_o_valid, n_o_valid;
    logic [2:0]    r_o_status, n_o_status;
    prl_pkg::t_rec r_o_rec, n_o_rec;
    logic          r_o_last, n_o_last;

    logic          mem_re, mem_we;
    logic [AW-1:0] mem_ra, mem_wa;
    prl_pkg::t_rec mem_wd;

    logic          acc, out_free, empty, full, pos_neg1, pos_bad, pos_lt;
    logic [6:0]    pos_u;
    logic [6:0]    cnt7;
    logic [AW-1:0] cnt_a, pos_a, step_src, step_dst;
    logic          ins_go;
    logic [2:0]    ins_st;
    logic [AW-1:0] ins_k;
    logic          del_go;
    logic [2:0]    del_st;
    logic [AW-1:0] del_k;
    logic [CW-1:0] ins_moves, del_moves;

    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = r_o_valid;
    assign o_status    = r_o_status;
    assign o_out_id    = r_o_rec.id;
    assign o_out_w0    = r_o_rec.w0;
    assign o_out_w1    = r_o_rec.w1;
    assign o_out_w2    = r_o_rec.w2;
    assign o_out_w3    = r_o_rec.w3;
    assign o_out_score = r_o_rec.score;
    assign o_last      = r_o_last;

    assign acc      = i_valid && o_ready;
    assign out_free = !r_o_valid || i_ready;
    assign empty    = (r_count == '0);
    assign full     = (r_count == CW'(CAPACITY));
    assign pos_u    = i_pos;
    assign cnt7     = 7'(r_count);
    assign pos_neg1 = (pos_u == 7'h7f);
    assign pos_bad  = pos_u[6] && !pos_neg1;
    assign pos_lt   = !pos_u[6] && (pos_u < cnt7);
    assign cnt_a    = r_count[AW-1:0];
    assign pos_a    = pos_u[AW-1:0];
    assign step_src = r_down ? (r_src - AW'(1)) : (r_src + AW'(1));
    assign step_dst = r_down ? (r_dst - AW'(1)) : (r_dst + AW'(1));

    // insert / append index checks, full check comes last
    always_comb begin
        ins_go = 1'b0;
        ins_st = prl_pkg::ST_OK;
        ins_k  = cnt_a;
        if (i_op == prl_pkg::OP_APPEND) begin
            ins_go = 1'b1;
        end else if (pos_bad) begin
            ins_st = prl_pkg::ST_BAD_INDEX;
        end else if (empty) begin
            if (pos_u == 7'd0) begin
                ins_go = 1'b1;
                ins_k  = '0;
            end else begin
                ins_st = prl_pkg::ST_NOT_REACHED;
            end
        end else if (pos_neg1) begin
            ins_go = 1'b1;
        end else if (pos_lt) begin
            ins_go = 1'b1;
            ins_k  = pos_a;
        end else begin
            ins_st = prl_pkg::ST_NOT_REACHED;
        end
        if (ins_go && full) begin
            ins_go = 1'b0;
            ins_st = prl_pkg::ST_FULL;
        end
        ins_moves = r_count - CW'(ins_k);
    end

    always_comb begin
        del_go = 1'b0;
        del_st = prl_pkg::ST_OK;
        del_k  = cnt_a - AW'(1);
        if (pos_bad) begin
            del_st = prl_pkg::ST_BAD_INDEX;
        end else if (empty) begin
            del_st = prl_pkg::ST_EMPTY;
        end else if (pos_neg1) begin
            del_go = 1'b1;
        end else if (pos_lt) begin
            del_go = 1'b1;
            del_k  = pos_a;
        end else begin
            del_st = prl_pkg::ST_NOT_REACHED;
        end
        del_moves = r_count - CW'(1) - CW'(del_k);
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_src      = r_src;
        n_dst      = r_dst;
        n_k        = r_k;
        n_left     = r_left;
        n_down     = r_down;
        n_cmt_ins  = r_cmt_ins;
        n_cmt_del  = r_cmt_del;
        n_st       = r_st;
        n_o_valid  = r_o_valid && !i_ready;
        n_o_status = r_o_status;
        n_o_rec    = r_o_rec;
        n_o_last   = r_o_last;
        mem_re     = 1'b0;
        mem_ra     = r_src;
        mem_we     = 1'b0;
        mem_wa     = r_dst;
        mem_wd     = r_rdata;

        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_cmt_ins = 1'b0;
                    n_cmt_del = 1'b0;
                    case (i_op)
                        prl_pkg::OP_APPEND, prl_pkg::OP_INSERT: begin
                            n_st = ins_st;
                            n_k  = ins_k;
                            if (ins_go) begin
                                n_cmt_ins = 1'b1;
                                n_src     = cnt_a - AW'(1);
                                n_dst     = cnt_a;
                                n_left    = ins_moves;
                                n_down    = 1'b1;
                                n_state   = (ins_moves != '0) ? S_MOVE_RD : S_RESP;
                            end else begin
                                n_state = S_RESP;
                            end
                        end
                        prl_pkg::OP_DELETE: begin
                            n_st = del_st;
                            if (del_go) begin
                                n_cmt_del = 1'b1;
                                n_src     = del_k + AW'(1);
                                n_dst     = del_k;
                                n_left    = del_moves;
                                n_down    = 1'b0;
                                n_state   = (del_moves != '0) ? S_MOVE_RD : S_RESP;
                            end else begin
                                n_state = S_RESP;
                            end
                        end
                        prl_pkg::OP_DUMP_REV, prl_pkg::OP_DUMP_FWD: begin
                            if (empty) begin
                                n_st    = prl_pkg::ST_EMPTY;
                                n_state = S_RESP;
                            end else begin
                                n_down  = (i_op == prl_pkg::OP_DUMP_REV);
                                n_src   = (i_op == prl_pkg::OP_DUMP_REV) ?
                                          (cnt_a - AW'(1)) : '0;
                                n_left  = r_count;
                                n_state = S_DUMP_RD;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_MOVE_RD: begin
                mem_re  = 1'b1;
                n_state = S_MOVE_WR;
            end
            S_MOVE_WR: begin
                // write the row read last cycle, fetch the next source meanwhile
                mem_we = 1'b1;
                if (r_left != CW'(1)) begin
                    mem_re = 1'b1;
                    mem_ra = step_src;
                    n_src  = step_src;
                    n_dst  = step_dst;
                    n_left = r_left - CW'(1);
                end else begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_st;
                    n_o_rec    = '0;
                    n_o_last   = 1'b1;
                    n_state    = S_IDLE;
                    if (r_cmt_ins) begin
                        mem_we  = 1'b1;
                        mem_wa  = r_k;
                        mem_wd  = r_new;
                        n_count = r_count + CW'(1);
                    end else if (r_cmt_del) begin
                        n_count = r_count - CW'(1);
                    end
                end
            end
            S_DUMP_RD: begin
                mem_re  = 1'b1;
                n_state = S_DUMP_LD;
            end
            S_DUMP_LD: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = prl_pkg::ST_RECORD;
                    n_o_rec    = r_rdata;
                    n_o_last   = (r_left == CW'(1));
                    if (r_left == CW'(1)) begin
                        n_state = S_IDLE;
                    end else begin
                        mem_re = 1'b1;
                        mem_ra = step_src;
                        n_src  = step_src;
                        n_left = r_left - CW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
            r_cmt_ins <= 1'b0;
            r_cmt_del <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
            r_cmt_ins <= n_cmt_ins;
            r_cmt_del <= n_cmt_del;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src      <= n_src;
        r_dst      <= n_dst;
        r_k        <= n_k;
        r_left     <= n_left;
        r_down     <= n_down;
        r_st       <= n_st;
        r_o_status <= n_o_status;
        r_o_rec    <= n_o_rec;
        r_o_last   <= n_o_last;
        if (acc) begin
            r_new.id    <= i_rec_id;
            r_new.w0    <= i_name_w0 & MASK0;
            r_new.w1    <= i_name_w1 & MASK1;
            r_new.w2    <= i_name_w2 & MASK2;
            r_new.w3    <= i_name_w3 & MASK3;
            r_new.score <= i_score_bits;
        end
    end

    // record memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_ra];
        end
    end

endmodule
`default_nettype wire
